>>> rtl/ldsolv_pkg.sv
package ldsolv_pkg;

  localparam int DATA_WIDTH_DEF = 32;

  // result status codes
  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_NODIV = 2'd1;
  localparam logic [1:0] ST_DEGEN = 2'd2;

  // microprogram step addresses
  localparam int STEP_W = 4;
  localparam logic [STEP_W-1:0] S_IDLE  = 4'd0;
  localparam logic [STEP_W-1:0] S_ZCHK  = 4'd1;
  localparam logic [STEP_W-1:0] S_LOOP  = 4'd2;
  localparam logic [STEP_W-1:0] S_QDIV  = 4'd3;
  localparam logic [STEP_W-1:0] S_QWAIT = 4'd4;
  localparam logic [STEP_W-1:0] S_MULS  = 4'd5;
  localparam logic [STEP_W-1:0] S_UPDS  = 4'd6;
  localparam logic [STEP_W-1:0] S_UPDT  = 4'd7;
  localparam logic [STEP_W-1:0] S_FIN   = 4'd8;
  localparam logic [STEP_W-1:0] S_KWAIT = 4'd9;
  localparam logic [STEP_W-1:0] S_KCHK  = 4'd10;
  localparam logic [STEP_W-1:0] S_MULX  = 4'd11;
  localparam logic [STEP_W-1:0] S_MULY  = 4'd12;
  localparam logic [STEP_W-1:0] S_OWAIT = 4'd13;
  localparam logic [STEP_W-1:0] S_OUT   = 4'd14;
  localparam logic [STEP_W-1:0] S_DEGEN = 4'd15;

  // jump conditions: taken means go to the target, otherwise step on
  localparam logic [2:0] JC_NEXT     = 3'd0;
  localparam logic [2:0] JC_ALWAYS   = 3'd1;
  localparam logic [2:0] JC_NO_IN    = 3'd2;
  localparam logic [2:0] JC_BOTHZERO = 3'd3;
  localparam logic [2:0] JC_R2ZERO   = 3'd4;
  localparam logic [2:0] JC_DIVBUSY  = 3'd5;
  localparam logic [2:0] JC_NODIV    = 3'd6;
  localparam logic [2:0] JC_OUTBUSY  = 3'd7;

  // multiplier operand pairs
  localparam logic [1:0] MS_Q_S2 = 2'd0;
  localparam logic [1:0] MS_Q_T2 = 2'd1;
  localparam logic [1:0] MS_S1_K = 2'd2;
  localparam logic [1:0] MS_T1_K = 2'd3;

  typedef struct packed {
    logic [2:0]        jc;
    logic [STEP_W-1:0] tgt;
    logic              ld_in;
    logic              div_start;
    logic              div_rhs;
    logic              lat_q;
    logic              mul_en;
    logic [1:0]        mul_sel;
    logic              upd_s;
    logic              upd_rt;
    logic              lat_k;
    logic              ld_px;
    logic              ld_py;
    logic              set_degen;
    logic              ld_out;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic both_zero;
    logic r2_zero;
    logic div_done;
    logic nodiv;
    logic out_busy;
  } flags_t;

  typedef struct packed {
    logic done;
    logic rem_zero;
  } div_st_t;

  // microcode store
  function automatic ctl_t ucode(input logic [STEP_W-1:0] step);
    ctl_t w;
    w = '0;
    unique case (step)
      S_IDLE: begin
        w.jc = JC_NO_IN; w.tgt = S_IDLE; w.ld_in = 1'b1;
      end
      S_ZCHK: begin
        w.jc = JC_BOTHZERO; w.tgt = S_DEGEN;
      end
      S_LOOP: begin
        w.jc = JC_R2ZERO; w.tgt = S_FIN;
      end
      S_QDIV: begin
        w.div_start = 1'b1;
      end
      S_QWAIT: begin
        w.jc = JC_DIVBUSY; w.tgt = S_QWAIT; w.lat_q = 1'b1;
      end
      S_MULS: begin
        w.mul_en = 1'b1; w.mul_sel = MS_Q_S2;
      end
      S_UPDS: begin
        w.upd_s = 1'b1; w.mul_en = 1'b1; w.mul_sel = MS_Q_T2;
      end
      S_UPDT: begin
        w.upd_rt = 1'b1; w.jc = JC_ALWAYS; w.tgt = S_LOOP;
      end
      S_FIN: begin
        w.div_start = 1'b1; w.div_rhs = 1'b1;
      end
      S_KWAIT: begin
        w.jc = JC_DIVBUSY; w.tgt = S_KWAIT; w.lat_k = 1'b1;
      end
      S_KCHK: begin
        w.jc = JC_NODIV; w.tgt = S_OWAIT; w.mul_en = 1'b1; w.mul_sel = MS_S1_K;
      end
      S_MULX: begin
        w.ld_px = 1'b1; w.mul_en = 1'b1; w.mul_sel = MS_T1_K;
      end
      S_MULY: begin
        w.ld_py = 1'b1;
      end
      S_OWAIT: begin
        w.jc = JC_OUTBUSY; w.tgt = S_OWAIT;
      end
      S_OUT: begin
        w.ld_out = 1'b1; w.jc = JC_ALWAYS; w.tgt = S_IDLE;
      end
      S_DEGEN: begin
        w.set_degen = 1'b1; w.jc = JC_ALWAYS; w.tgt = S_OWAIT;
      end
    endcase
    return w;
  endfunction

endpackage

>>> rtl/ldsolv_if.sv
interface ldsolv_eqn_if #(parameter int W = ldsolv_pkg::DATA_WIDTH_DEF);
  logic                valid;
  logic                ready;
  logic [W-2:0]        coef_a;
  logic [W-2:0]        coef_b;
  logic signed [W-1:0] rhs;

  modport source (output valid, coef_a, coef_b, rhs, input ready);
  modport sink (input valid, coef_a, coef_b, rhs, output ready);
endinterface

interface ldsolv_res_if #(parameter int W = ldsolv_pkg::DATA_WIDTH_DEF);
  logic                  valid;
  logic                  ready;
  logic [1:0]            status;
  logic [W-2:0]          divisor;
  logic signed [W-1:0]   bezout_x;
  logic signed [W-1:0]   bezout_y;
  logic signed [2*W-1:0] solution_x;
  logic signed [2*W-1:0] solution_y;

  modport source (output valid, status, divisor, bezout_x, bezout_y, solution_x,
                  solution_y, input ready);
  modport sink (input valid, status, divisor, bezout_x, bezout_y, solution_x,
                solution_y, output ready);
endinterface

>>> rtl/ldsolv_div.sv
module ldsolv_div #(
  parameter int W = ldsolv_pkg::DATA_WIDTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  start,
  input  logic [W-1:0]          dividend,
  input  logic [W-1:0]          divisor,
  output logic [W-1:0]          quot,
  output logic [W-1:0]          rem,
  output ldsolv_pkg::div_st_t   st
);
  import ldsolv_pkg::*;

  localparam int CNT_W = (W > 1) ? $clog2(W) : 1;

  logic             busy;
  logic             done;
  logic [CNT_W-1:0] cnt;
  logic [W-1:0]     dvs;
  logic [W:0]       sh;
  logic [W:0]       diff;
  logic             ge;

  // one quotient bit per cycle, restoring
  assign sh   = {rem, quot[W-1]};
  assign diff = sh - {1'b0, dvs};
  assign ge   = (sh >= {1'b0, dvs});

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      done <= 1'b0;
      cnt  <= CNT_W'(W - 1);
    end else if (busy) begin
      cnt <= cnt - 1'b1;
      if (cnt == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end else begin
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dvs  <= divisor;
    end else if (busy) begin
      quot <= {quot[W-2:0], ge};
      rem  <= ge ? diff[W-1:0] : sh[W-1:0];
    end
  end

  assign st.done     = done;
  assign st.rem_zero = (rem == '0);

`ifndef SYNTHESIS
  a_start_busy: assert property (@(posedge clk) disable iff (rst) start |=> busy)
    else $error("divider not busy after start");
  a_done_idle: assert property (@(posedge clk) disable iff (rst) done |-> !busy)
    else $error("divider done while still busy");
`endif

endmodule

>>> rtl/ldsolv_seq.sv
module ldsolv_seq (
  input  logic                clk,
  input  logic                rst,
  input  ldsolv_pkg::flags_t  flags,
  output ldsolv_pkg::ctl_t    ctl
);
  import ldsolv_pkg::*;

  logic [STEP_W-1:0] pc;
  logic [STEP_W-1:0] pc_next;
  logic              take;

  assign ctl = ucode(pc);

  always_comb begin
    unique case (ctl.jc)
      JC_NEXT:     take = 1'b0;
      JC_ALWAYS:   take = 1'b1;
      JC_NO_IN:    take = !flags.in_valid;
      JC_BOTHZERO: take = flags.both_zero;
      JC_R2ZERO:   take = flags.r2_zero;
      JC_DIVBUSY:  take = !flags.div_done;
      JC_NODIV:    take = flags.nodiv;
      JC_OUTBUSY:  take = flags.out_busy;
    endcase
    pc_next = take ? ctl.tgt : pc + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= S_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

>>> rtl/ldsolv_dp.sv
module ldsolv_dp #(
  parameter int W = ldsolv_pkg::DATA_WIDTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  ldsolv_pkg::ctl_t     ctl,
  input  ldsolv_pkg::div_st_t  dst,
  input  logic [W-1:0]         quot,
  input  logic [W-1:0]         rem,
  output logic [W-1:0]         dividend,
  output logic [W-1:0]         divisor,
  output ldsolv_pkg::flags_t   flags,
  ldsolv_eqn_if.sink           eqn,
  ldsolv_res_if.source         res
);
  import ldsolv_pkg::*;

  logic [W-2:0]          r1;
  logic [W-2:0]          r2;
  logic [W-2:0]          q;
  logic [W-2:0]          nr;
  logic signed [W-1:0]   s1;
  logic signed [W-1:0]   s2;
  logic signed [W-1:0]   t1;
  logic signed [W-1:0]   t2;
  logic signed [W-1:0]   c;
  logic signed [W-1:0]   k;
  logic [1:0]            stat;
  logic signed [2*W-1:0] prod;
  logic signed [2*W-1:0] px;
  logic signed [2*W-1:0] py;
  logic signed [W-1:0]   mul_a;
  logic signed [W-1:0]   mul_b;
  logic signed [2*W-1:0] mul_p;
  logic [W-1:0]          c_mag;
  logic [W-1:0]          k_next;
  logic                  in_fire;
  logic                  out_valid;

  assign eqn.ready = ctl.ld_in;
  assign in_fire   = eqn.valid && ctl.ld_in;

  // divider operands: euclid step or rhs over the gcd
  assign c_mag    = c[W-1] ? (~c + 1'b1) : c;
  assign dividend = ctl.div_rhs ? c_mag : {1'b0, r1};
  assign divisor  = ctl.div_rhs ? {1'b0, r1} : {1'b0, r2};
  assign k_next   = c[W-1] ? (~quot + 1'b1) : quot;

  always_comb begin
    case (ctl.mul_sel)
      MS_Q_S2: begin mul_a = $signed({1'b0, q}); mul_b = s2; end
      MS_Q_T2: begin mul_a = $signed({1'b0, q}); mul_b = t2; end
      MS_S1_K: begin mul_a = s1; mul_b = k; end
      default: begin mul_a = t1; mul_b = k; end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  always_ff @(posedge clk) begin
    if (in_fire) begin
      r1   <= eqn.coef_a;
      r2   <= eqn.coef_b;
      c    <= eqn.rhs;
      s1   <= W'(1);
      s2   <= '0;
      t1   <= '0;
      t2   <= W'(1);
      stat <= ST_OK;
      px   <= '0;
      py   <= '0;
    end else begin
      if (ctl.lat_q && dst.done) begin
        q  <= quot[W-2:0];
        nr <= rem[W-2:0];
      end
      if (ctl.lat_k && dst.done) begin
        k    <= $signed(k_next);
        stat <= dst.rem_zero ? ST_OK : ST_NODIV;
      end
      if (ctl.upd_s) begin
        s1 <= s2;
        s2 <= s1 - prod[W-1:0];
      end
      if (ctl.upd_rt) begin
        t1 <= t2;
        t2 <= t1 - prod[W-1:0];
        r1 <= r2;
        r2 <= nr;
      end
      if (ctl.ld_px) px <= prod;
      if (ctl.ld_py) py <= prod;
      if (ctl.set_degen) begin
        stat <= ST_DEGEN;
        s1   <= '0;
        t1   <= '0;
      end
    end
    if (ctl.mul_en) prod <= mul_p;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ctl.ld_out) begin
      out_valid <= 1'b1;
    end else if (res.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.ld_out) begin
      res.status     <= stat;
      res.divisor    <= r1;
      res.bezout_x   <= s1;
      res.bezout_y   <= t1;
      res.solution_x <= px;
      res.solution_y <= py;
    end
  end

  assign res.valid = out_valid;

  assign flags.in_valid  = eqn.valid;
  assign flags.both_zero = (r1 == '0) && (r2 == '0);
  assign flags.r2_zero   = (r2 == '0);
  assign flags.div_done  = dst.done;
  assign flags.nodiv     = (stat == ST_NODIV);
  assign flags.out_busy  = out_valid && !res.ready;

`ifndef SYNTHESIS
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    ctl.ld_out |-> !(out_valid && !res.ready))
    else $error("result register overwritten while held");
  a_loop_nonzero: assert property (@(posedge clk) disable iff (rst)
    ctl.upd_rt |-> (r2 != '0))
    else $error("euclid step with zero remainder");
`endif

endmodule

>>> rtl/linear_diophantine_solver.sv
// solves a*x + b*y = c for one equation per beat: a microcoded sequencer walks
// the extended euclidean recurrence on a shared restoring divider and one
// multiplier, then divides rhs by the gcd and scales the bezout pair. each
// quotient step runs the divider, which makes one quotient bit per cycle; a
// finished item also waits while a held result is not yet taken. the input
// is taken only when the sequencer is idle; a finished result sits in its own
// register, so the next equation is accepted while the previous result waits.
// status 2 marks both coefficients zero (all other fields zero), status 1
// marks a gcd that does not divide rhs (divisor and bezout pair still given,
// solutions zero). no state survives from one item to the next.
module linear_diophantine_solver #(
  parameter int DATA_WIDTH = ldsolv_pkg::DATA_WIDTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  ldsolv_eqn_if.sink     eqn,
  ldsolv_res_if.source   res
);
  import ldsolv_pkg::*;

  ctl_t                  ctl;
  flags_t                flags;
  div_st_t               dst;
  logic [DATA_WIDTH-1:0] quot;
  logic [DATA_WIDTH-1:0] rem;
  logic [DATA_WIDTH-1:0] dividend;
  logic [DATA_WIDTH-1:0] divisor;

  // step counter and microcode store, jumps on datapath flags
  ldsolv_seq u_seq (
    .clk   (clk),
    .rst   (rst),
    .flags (flags),
    .ctl   (ctl)
  );

  // shared divider: quotient for euclid, then rhs over the gcd
  ldsolv_div #(.W(DATA_WIDTH)) u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (ctl.div_start),
    .dividend (dividend),
    .divisor  (divisor),
    .quot     (quot),
    .rem      (rem),
    .st       (dst)
  );

  // remainders, bezout pairs, multiplier and the result register
  ldsolv_dp #(.W(DATA_WIDTH)) u_dp (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ctl),
    .dst      (dst),
    .quot     (quot),
    .rem      (rem),
    .dividend (dividend),
    .divisor  (divisor),
    .flags    (flags),
    .eqn      (eqn),
    .res      (res)
  );

endmodule
